[hdl/battery_status_estimator_defines.svh]
// Assertion macros used by bse_out.
// Each expects clk and rst_n in scope.
`ifndef BATTERY_STATUS_ESTIMATOR_DEFINES_SVH
`define BATTERY_STATUS_ESTIMATOR_DEFINES_SVH

// Same-cycle implication.
`define BSE_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bse_pkg.sv]
`timescale 1ns / 1ps

package bse_pkg;

    localparam int DIV_NUM_W = 28;
    localparam int DIV_DEN_W = 16;
    localparam int ENERGY_W  = 23;
    localparam int TIME_W    = 22;
    localparam int N_ENERGY  = 5;

    // Energy lane order
    localparam int E_REMAIN = 0;
    localparam int E_FULL   = 1;
    localparam int E_DESIGN = 2;
    localparam int E_EMPTY  = 3;
    localparam int E_RATE   = 4;

    // floor(p / 1000) == (p * MWH_RECIP) >> MWH_SHIFT for any 32-bit p
    localparam logic [31:0] MWH_RECIP     = 32'd2199023256;
    localparam int          MWH_SHIFT     = 41;
    localparam logic [15:0] MA_DEFAULT_MV = 16'd1000;
    localparam logic [15:0] RATE_UNKNOWN  = 16'hFFFF;
    localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
    localparam logic [6:0]  PCT_SCALE     = 7'd100;
    localparam logic [6:0]  HEALTH_MAX    = 7'd100;

    localparam logic [0:0] CFG_LOW_PERCENT    = 1'b0;
    localparam logic [0:0] CFG_ESTIMATE_LIMIT = 1'b1;

    localparam logic [6:0]  LOW_PERCENT_RST = 7'd10;
    localparam logic [17:0] EST_LIMIT_RST   = 18'd72000;

    typedef enum logic [2:0] {
        CS_UNKNOWN     = 3'd0,
        CS_CHARGING    = 3'd1,
        CS_DISCHARGING = 3'd2,
        CS_EMPTY       = 3'd3,
        CS_FULL        = 3'd4
    } charge_state_t;

    // Last field in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [6:0]  reported_percent;
        logic [16:0] reported_minutes;
        logic [2:0]  charge_flags;
        logic [15:0] remaining_capacity;
        logic [15:0] present_rate;
        logic [15:0] warning_capacity;
        logic [15:0] last_full_capacity;
        logic [15:0] design_capacity;
        logic [15:0] present_voltage_mv;
        logic [15:0] design_voltage_mv;
        logic        units_milliamp;
        logic        battery_present;
    } in_item_t;

    typedef struct packed {
        logic [4:0]          pad;
        logic                low_charge;
        logic [TIME_W-1:0]   time_to_full_s;
        logic [TIME_W-1:0]   time_to_empty_s;
        logic [2:0]          charge_state;
        logic [6:0]          health_percent;
        logic [15:0]         voltage_out_mv;
        logic [ENERGY_W-1:0] rate_mw;
        logic [ENERGY_W-1:0] energy_empty_mwh;
        logic [ENERGY_W-1:0] energy_design_mwh;
        logic [ENERGY_W-1:0] energy_full_mwh;
        logic [ENERGY_W-1:0] energy_mwh;
        logic                present_out;
    } out_item_t;

    // Fields that ride alongside the dividers
    typedef struct packed {
        logic                               present;
        charge_state_t                      state;
        logic [6:0]                         pct;
        logic                               min_pos;
        logic [TIME_W-1:0]                  min_sec;
        logic                               time_calc;
        logic                               health_ok;
        logic [N_ENERGY-1:0][ENERGY_W-1:0]  energy;
        logic [15:0]                        voltage;
    } side_t;

endpackage

[hdl/bse_front.sv]
`timescale 1ns / 1ps

module bse_front
    import bse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  in_item_t             in_item,
    output logic                 out_valid,
    output side_t                out_side,
    output logic [DIV_NUM_W-1:0] time_num,
    output logic [DIV_DEN_W-1:0] time_den,
    output logic [DIV_NUM_W-1:0] health_num,
    output logic [DIV_DEN_W-1:0] health_den
);

    // Stage 1: fallbacks, clamps, state decode
    logic                s1_valid_reg;
    logic                s1_present_reg;
    charge_state_t       s1_state_reg;
    logic [6:0]          s1_pct_reg;
    logic                s1_min_pos_reg;
    logic [15:0]         s1_min_reg;
    logic                s1_time_calc_reg;
    logic                s1_health_ok_reg;
    logic [15:0]         s1_charge_reg;
    logic [15:0]         s1_rate_reg;
    logic [15:0]         s1_lf_reg;
    logic [15:0]         s1_dcap_reg;
    logic [15:0]         s1_mul_reg;
    logic [15:0]         s1_volt_reg;
    logic [15:0]         s1_raw_reg [N_ENERGY];

    logic [15:0]         dvol_next;
    logic [15:0]         volt_clamp_next;
    logic [15:0]         rate_next;
    charge_state_t       state_next;
    logic                min_pos_next;
    logic [15:0]         charge_next;

    always_comb
    begin
        dvol_next = (in_item.design_voltage_mv == '0) ? MA_DEFAULT_MV
                                                      : in_item.design_voltage_mv;
        if (in_item.present_voltage_mv == '0 || in_item.present_voltage_mv > dvol_next)
        begin
            volt_clamp_next = dvol_next;
        end
        else
        begin
            volt_clamp_next = in_item.present_voltage_mv;
        end
        if (in_item.present_rate == RATE_UNKNOWN || in_item.remaining_capacity == '0)
        begin
            rate_next = '0;
        end
        else
        begin
            rate_next = in_item.present_rate;
        end
        priority if (in_item.charge_flags[0])
        begin
            state_next = CS_DISCHARGING;
        end
        else if (in_item.charge_flags[1])
        begin
            state_next = CS_CHARGING;
        end
        else if (in_item.charge_flags[2])
        begin
            state_next = CS_EMPTY;
        end
        else
        begin
            state_next = CS_FULL;
        end
        min_pos_next = !in_item.reported_minutes[16] && (in_item.reported_minutes != '0);
        // Charging time works on the charge still missing, never negative
        if (state_next == CS_DISCHARGING)
        begin
            charge_next = in_item.remaining_capacity;
        end
        else if (in_item.last_full_capacity > in_item.remaining_capacity)
        begin
            charge_next = in_item.last_full_capacity - in_item.remaining_capacity;
        end
        else
        begin
            charge_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_present_reg   <= in_item.battery_present;
            s1_state_reg     <= state_next;
            s1_pct_reg       <= in_item.reported_percent;
            s1_min_pos_reg   <= min_pos_next;
            s1_min_reg       <= in_item.reported_minutes[15:0];
            s1_time_calc_reg <= !min_pos_next && (rate_next != '0)
                                && (in_item.charge_flags[0] || in_item.charge_flags[1]);
            s1_health_ok_reg <= (in_item.last_full_capacity != '0)
                                && (in_item.design_capacity != '0);
            s1_charge_reg    <= charge_next;
            s1_rate_reg      <= rate_next;
            s1_lf_reg        <= in_item.last_full_capacity;
            s1_dcap_reg      <= in_item.design_capacity;
            // Milliwatt mode scales by 1000/1000, which leaves the raw value
            s1_mul_reg       <= in_item.units_milliamp ? volt_clamp_next : MA_DEFAULT_MV;
            s1_volt_reg      <= in_item.units_milliamp ? volt_clamp_next
                                                       : in_item.present_voltage_mv;
            s1_raw_reg[E_REMAIN] <= in_item.remaining_capacity;
            s1_raw_reg[E_FULL]   <= in_item.last_full_capacity;
            s1_raw_reg[E_DESIGN] <= in_item.design_capacity;
            s1_raw_reg[E_EMPTY]  <= in_item.warning_capacity;
            s1_raw_reg[E_RATE]   <= rate_next;
        end
    end

    // Stage 2: raw times voltage, numerators
    logic                 s2_valid_reg;
    side_t                s2_side_reg;
    logic [31:0]          s2_prod_reg [N_ENERGY];
    logic [DIV_NUM_W-1:0] s2_time_num_reg;
    logic [DIV_DEN_W-1:0] s2_time_den_reg;
    logic [DIV_NUM_W-1:0] s2_health_num_reg;
    logic [DIV_DEN_W-1:0] s2_health_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N_ENERGY; k++)
            begin
                s2_prod_reg[k] <= 32'(s1_raw_reg[k]) * 32'(s1_mul_reg);
            end
            s2_time_num_reg   <= DIV_NUM_W'(s1_charge_reg) * DIV_NUM_W'(SEC_PER_HOUR);
            s2_time_den_reg   <= s1_rate_reg;
            s2_health_num_reg <= DIV_NUM_W'(s1_lf_reg) * DIV_NUM_W'(PCT_SCALE);
            s2_health_den_reg <= s1_dcap_reg;
            s2_side_reg.present   <= s1_present_reg;
            s2_side_reg.state     <= s1_state_reg;
            s2_side_reg.pct       <= s1_pct_reg;
            s2_side_reg.min_pos   <= s1_min_pos_reg;
            s2_side_reg.min_sec   <= TIME_W'(s1_min_reg) * TIME_W'(SEC_PER_MIN);
            s2_side_reg.time_calc <= s1_time_calc_reg;
            s2_side_reg.health_ok <= s1_health_ok_reg;
            s2_side_reg.energy    <= '0;
            s2_side_reg.voltage   <= s1_volt_reg;
        end
    end

    // Stage 3: divide by 1000 through the reciprocal
    logic                 s3_valid_reg;
    side_t                s3_side_reg;
    side_t                s3_side_next;
    logic [DIV_NUM_W-1:0] s3_time_num_reg;
    logic [DIV_DEN_W-1:0] s3_time_den_reg;
    logic [DIV_NUM_W-1:0] s3_health_num_reg;
    logic [DIV_DEN_W-1:0] s3_health_den_reg;
    logic [63:0]          recip_prod [N_ENERGY];

    always_comb
    begin
        s3_side_next = s2_side_reg;
        for (int k = 0; k < N_ENERGY; k++)
        begin
            recip_prod[k] = 64'(s2_prod_reg[k]) * 64'(MWH_RECIP);
            s3_side_next.energy[k] = recip_prod[k][MWH_SHIFT +: ENERGY_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_side_reg       <= s3_side_next;
            s3_time_num_reg   <= s2_time_num_reg;
            s3_time_den_reg   <= s2_time_den_reg;
            s3_health_num_reg <= s2_health_num_reg;
            s3_health_den_reg <= s2_health_den_reg;
        end
    end

    assign out_valid  = s3_valid_reg;
    assign out_side   = s3_side_reg;
    assign time_num   = s3_time_num_reg;
    assign time_den   = s3_time_den_reg;
    assign health_num = s3_health_num_reg;
    assign health_den = s3_health_den_reg;

endmodule

[hdl/bse_div.sv]
`timescale 1ns / 1ps

module bse_div
    import bse_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    output logic [DIV_NUM_W-1:0] quotient
);

    // Restoring division, one quotient bit per stage. The work word shifts
    // the dividend out at the top while quotient bits enter at the bottom.
    logic [DIV_NUM_W-1:0] work_reg [DIV_NUM_W];
    logic [DIV_DEN_W-1:0] rem_reg  [DIV_NUM_W-1];
    logic [DIV_DEN_W-1:0] den_reg  [DIV_NUM_W-1];

    for (genvar k = 0; k < DIV_NUM_W; k++)
    begin : g_stage
        logic [DIV_DEN_W-1:0] rem_in;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_NUM_W-1:0] work_in;
        logic [DIV_DEN_W:0]   shifted;
        logic [DIV_DEN_W:0]   diff;
        logic                 ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign den_in  = divisor;
            assign work_in = dividend;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign work_in = work_reg[k-1];
        end

        assign shifted = {rem_in, work_in[DIV_NUM_W-1]};
        assign diff    = shifted - {1'b0, den_in};
        assign ge      = (shifted >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                work_reg[k] <= {work_in[DIV_NUM_W-2:0], ge};
            end
        end

        if (k < DIV_NUM_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quotient = work_reg[DIV_NUM_W-1];

endmodule

[hdl/bse_delay.sv]
`timescale 1ns / 1ps

module bse_delay
    import bse_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  side_t in_side,
    output logic  out_valid,
    output side_t out_side
);

    // Match the divider depth so side fields meet their quotients
    logic  valid_reg [DIV_NUM_W];
    side_t side_reg  [DIV_NUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_NUM_W; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < DIV_NUM_W; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int k = 1; k < DIV_NUM_W; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[DIV_NUM_W-1];
    assign out_side  = side_reg[DIV_NUM_W-1];

endmodule

[hdl/bse_out.sv]
`timescale 1ns / 1ps
`include "battery_status_estimator_defines.svh"

module bse_out
    import bse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  side_t                in_side,
    input  logic [DIV_NUM_W-1:0] time_q,
    input  logic [DIV_NUM_W-1:0] health_q,
    input  logic [6:0]           low_percent,
    input  logic [17:0]          estimate_limit,
    output logic                 pipe_en,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item
);

    out_item_t result;
    logic [TIME_W-1:0] est;
    logic [TIME_W-1:0] time_val;

    always_comb
    begin
        // Computed estimates beyond the limit read as zero
        if (time_q > DIV_NUM_W'(estimate_limit))
        begin
            est = '0;
        end
        else
        begin
            est = time_q[TIME_W-1:0];
        end
        if (in_side.min_pos)
        begin
            time_val = in_side.min_sec;
        end
        else if (in_side.time_calc)
        begin
            time_val = est;
        end
        else
        begin
            time_val = '0;
        end

        result = '0;
        if (in_side.present)
        begin
            result.present_out       = 1'b1;
            result.energy_mwh        = in_side.energy[E_REMAIN];
            result.energy_full_mwh   = in_side.energy[E_FULL];
            result.energy_design_mwh = in_side.energy[E_DESIGN];
            result.energy_empty_mwh  = in_side.energy[E_EMPTY];
            result.rate_mw           = in_side.energy[E_RATE];
            result.voltage_out_mv    = in_side.voltage;
            if (in_side.health_ok)
            begin
                result.health_percent = (health_q > DIV_NUM_W'(HEALTH_MAX))
                                        ? HEALTH_MAX : health_q[6:0];
            end
            result.charge_state = in_side.state;
            if (in_side.state == CS_DISCHARGING)
            begin
                result.time_to_empty_s = time_val;
                result.low_charge      = (in_side.pct < low_percent);
            end
            if (in_side.state == CS_CHARGING)
            begin
                result.time_to_full_s = time_val;
            end
        end
    end

    // Output register plus skid stage; the pipeline stalls only when the skid is full
    logic      out_valid_reg;
    logic      skid_valid_reg;
    out_item_t out_reg;
    out_item_t skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (!skid_valid_reg && in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (!skid_valid_reg)
        begin
            skid_reg <= result;
        end
    end

    assign pipe_en   = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    logic out_absent;
    logic out_not_discharging;
    logic discharge_fields_clear;

    assign out_absent             = out_valid_reg && !out_reg.present_out;
    assign out_not_discharging    = out_valid_reg && (out_reg.charge_state != CS_DISCHARGING);
    assign discharge_fields_clear = (out_reg.time_to_empty_s == '0) && !out_reg.low_charge;

    `BSE_ASSERT_HOLDS(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid without output")
    `BSE_ASSERT_NEXT(a_skid_kept, skid_valid_reg && !out_ready, skid_valid_reg, "skid lost")
    `BSE_ASSERT_HOLDS(a_absent_zero, out_absent, out_reg == '0, "absent battery not zero")
    `BSE_ASSERT_HOLDS(a_health_range, out_valid_reg, out_reg.health_percent <= HEALTH_MAX, "health")
    `BSE_ASSERT_HOLDS(a_one_time, out_not_discharging, discharge_fields_clear, "discharge fields")

endmodule

[hdl/battery_status_estimator.sv]
// Battery status estimator.
// Input stream s_*: one battery reading per request, fields packed in s_tdata.
// Output stream m_*: one status result per reading, same order, packed in m_tdata.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 low percent threshold, 1 estimate limit in seconds); write only while idle.
// Throughput: one reading per cycle while s_tready is high. The path from acceptance to
// m_tvalid runs through three front stages (clamp, multiply, reciprocal scale), the
// 28-stage divider (one quotient bit per stage) and the output register.
// Times and health come from two parallel pipelined dividers.
// Reset clears all valid bits and loads the registers with 10 and 72000.
// When m_tready is low the output holds; one more result lands in a skid
// register, then s_tready drops and the whole pipeline freezes in place.
`timescale 1ns / 1ps

module battery_status_estimator
    import bse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // battery_present, units_milliamp, design_voltage_mv, present_voltage_mv,
    // design_capacity, last_full_capacity, warning_capacity, present_rate,
    // remaining_capacity, charge_flags, reported_minutes, reported_percent, pad
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // present_out, energy_mwh, energy_full_mwh, energy_design_mwh,
    // energy_empty_mwh, rate_mw, voltage_out_mv, health_percent, charge_state,
    // time_to_empty_s, time_to_full_s, low_charge, pad
    output logic [191:0] m_tdata,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [17:0]  cfg_data
);

    logic [6:0]  low_percent_reg;
    logic [17:0] est_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_percent_reg <= LOW_PERCENT_RST;
            est_limit_reg   <= EST_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOW_PERCENT:    low_percent_reg <= cfg_data[6:0];
                CFG_ESTIMATE_LIMIT: est_limit_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    logic                 en;
    logic                 front_valid;
    side_t                front_side;
    logic [DIV_NUM_W-1:0] time_num;
    logic [DIV_DEN_W-1:0] time_den;
    logic [DIV_NUM_W-1:0] health_num;
    logic [DIV_DEN_W-1:0] health_den;
    logic [DIV_NUM_W-1:0] time_q;
    logic [DIV_NUM_W-1:0] health_q;
    logic                 dly_valid;
    side_t                dly_side;
    out_item_t            out_item;

    assign s_tready = en;

    bse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_item    (in_item_t'(s_tdata)),
        .out_valid  (front_valid),
        .out_side   (front_side),
        .time_num   (time_num),
        .time_den   (time_den),
        .health_num (health_num),
        .health_den (health_den)
    );

    bse_div u_time_div (
        .clk      (clk),
        .en       (en),
        .dividend (time_num),
        .divisor  (time_den),
        .quotient (time_q)
    );

    bse_div u_health_div (
        .clk      (clk),
        .en       (en),
        .dividend (health_num),
        .divisor  (health_den),
        .quotient (health_q)
    );

    bse_delay u_delay (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_side   (front_side),
        .out_valid (dly_valid),
        .out_side  (dly_side)
    );

    bse_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (dly_valid),
        .in_side        (dly_side),
        .time_q         (time_q),
        .health_q       (health_q),
        .low_percent    (low_percent_reg),
        .estimate_limit (est_limit_reg),
        .pipe_en        (en),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_item       (out_item)
    );

    assign m_tdata = out_item;

endmodule

[bench/battery_status_estimator_tb.sv]
`timescale 1ns / 1ps

module battery_status_estimator_tb
    import bse_pkg::*;
();

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    in_item_t    s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    out_item_t   m_tdata;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = CFG_LOW_PERCENT;
    logic [17:0] cfg_data = '0;

    // Register copies used by the status predictor
    logic [6:0]  low_pct = LOW_PERCENT_RST;
    logic [17:0] limit_s = EST_LIMIT_RST;

    in_item_t    reading_q[$];
    out_item_t   status_q[$];
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;
    logic        took_req = 1'b0;

    battery_status_estimator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] to_mwh(logic [63:0] raw, logic ma, logic [63:0] mv);
        return ma ? (raw * mv) / 64'd1000 : raw;
    endfunction

    function automatic logic [63:0] time_estimate(logic [63:0] charge, logic [63:0] rate);
        logic [63:0] t;
        t = (64'd3600 * charge) / rate;
        if (t > 64'(limit_s))
            t = 64'd0;
        return t;
    endfunction

    function automatic out_item_t status_of(in_item_t r);
        out_item_t     o;
        logic [63:0]   dv, v, rate, cap, lf, dc, lc, t_empty, t_full, health;
        logic          min_pos;
        charge_state_t st;
        o = '0;
        if (!r.battery_present)
            return o;
        dv = 64'(r.design_voltage_mv);
        v = 64'(r.present_voltage_mv);
        cap = 64'(r.remaining_capacity);
        lf = 64'(r.last_full_capacity);
        dc = 64'(r.design_capacity);
        lc = 64'(r.warning_capacity);
        rate = (r.present_rate == RATE_UNKNOWN) ? 64'd0 : 64'(r.present_rate);
        if (r.units_milliamp)
        begin
            if (dv == 64'd0)
                dv = 64'd1000;
            if (v == 64'd0 || v > dv)
                v = dv;
        end
        if (cap == 64'd0)
            rate = 64'd0;
        health = 64'd0;
        if (lf != 64'd0 && dc != 64'd0)
        begin
            health = (64'd100 * lf) / dc;
            if (health > 64'd100)
                health = 64'd100;
        end
        min_pos = !r.reported_minutes[16] && (r.reported_minutes != '0);
        t_empty = 64'd0;
        t_full = 64'd0;
        // discharging beats charging, which beats critical
        if (r.charge_flags[0])
        begin
            st = CS_DISCHARGING;
            if (min_pos)
                t_empty = 64'(r.reported_minutes) * 64'd60;
            else if (rate != 64'd0)
                t_empty = time_estimate(cap, rate);
        end
        else if (r.charge_flags[1])
        begin
            st = CS_CHARGING;
            if (min_pos)
                t_full = 64'(r.reported_minutes) * 64'd60;
            else if (rate != 64'd0 && lf > cap)
                t_full = time_estimate(lf - cap, rate);
        end
        else if (r.charge_flags[2])
            st = CS_EMPTY;
        else
            st = CS_FULL;
        o.present_out = 1'b1;
        o.energy_mwh = ENERGY_W'(to_mwh(cap, r.units_milliamp, v));
        o.energy_full_mwh = ENERGY_W'(to_mwh(lf, r.units_milliamp, v));
        o.energy_design_mwh = ENERGY_W'(to_mwh(dc, r.units_milliamp, v));
        o.energy_empty_mwh = ENERGY_W'(to_mwh(lc, r.units_milliamp, v));
        o.rate_mw = ENERGY_W'(to_mwh(rate, r.units_milliamp, v));
        o.voltage_out_mv = v[15:0];
        o.health_percent = health[6:0];
        o.charge_state = st;
        o.time_to_empty_s = t_empty[TIME_W-1:0];
        o.time_to_full_s = t_full[TIME_W-1:0];
        o.low_charge = (st == CS_DISCHARGING) && (r.reported_percent < low_pct);
        return o;
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 100));
            3, 4: return 16'($urandom_range(1, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_item_t random_reading();
        in_item_t r;
        int       q;
        r = '0;
        r.battery_present = ($urandom_range(19) != 0);
        r.units_milliamp = 1'($urandom_range(1));
        r.design_voltage_mv = ($urandom_range(3) == 0) ? pick16()
            : 16'($urandom_range(3000, 20000));
        r.present_voltage_mv = ($urandom_range(3) == 0) ? pick16()
            : 16'($urandom_range(2500, 21000));
        r.design_capacity = pick16();
        r.last_full_capacity = ($urandom_range(2) == 0) ? pick16()
            : 16'($urandom_range(r.design_capacity / 2, r.design_capacity));
        r.warning_capacity = pick16();
        r.remaining_capacity = ($urandom_range(3) != 0)
            ? 16'($urandom_range(r.last_full_capacity)) : pick16();
        case ($urandom_range(9))
            0: r.present_rate = RATE_UNKNOWN;
            1: r.present_rate = 16'd0;
            2, 3, 4:
            begin
                // keep the ratio near the limit so both outcomes show up
                q = int'(r.remaining_capacity) / int'($urandom_range(1, 40)) + 1;
                r.present_rate = 16'(q);
            end
            default: r.present_rate = pick16();
        endcase
        r.charge_flags = 3'($urandom_range(7));
        case ($urandom_range(9))
            0, 1: r.reported_minutes = 17'h1FFFF;
            2: r.reported_minutes = 17'd65535;
            3: r.reported_minutes = 17'($urandom_range(1, 600));
            4: r.reported_minutes = 17'($urandom_range(1, 65535));
            default: r.reported_minutes = 17'd0;
        endcase
        r.reported_percent = ($urandom_range(15) == 0) ? 7'($urandom_range(101, 127))
            : 7'($urandom_range(100));
        return r;
    endfunction

    task automatic push_reading(in_item_t r);
        reading_q.push_back(r);
        n_sent++;
    endtask

    task automatic write_reg(logic [0:0] idx, logic [17:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_LOW_PERCENT)
            low_pct = val[6:0];
        else
            limit_s = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            n_errors++;
            if (n_errors <= 60)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Driver: hold the request until accepted, then advance or idle
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || took_req)
            begin
                if (reading_q.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    s_tdata <= reading_q.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        out_item_t want;
        took_req <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                status_q.push_back(status_of(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (status_q.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: result with none expected, got %h", $time, m_tdata);
                end
                else
                begin
                    want = status_q.pop_front();
                    n_checked++;
                    check_field("present_out", 32'(want.present_out),
                        32'(m_tdata.present_out));
                    check_field("energy_mwh", 32'(want.energy_mwh),
                        32'(m_tdata.energy_mwh));
                    check_field("energy_full_mwh", 32'(want.energy_full_mwh),
                        32'(m_tdata.energy_full_mwh));
                    check_field("energy_design_mwh", 32'(want.energy_design_mwh),
                        32'(m_tdata.energy_design_mwh));
                    check_field("energy_empty_mwh", 32'(want.energy_empty_mwh),
                        32'(m_tdata.energy_empty_mwh));
                    check_field("rate_mw", 32'(want.rate_mw), 32'(m_tdata.rate_mw));
                    check_field("voltage_out_mv", 32'(want.voltage_out_mv),
                        32'(m_tdata.voltage_out_mv));
                    check_field("health_percent", 32'(want.health_percent),
                        32'(m_tdata.health_percent));
                    check_field("charge_state", 32'(want.charge_state),
                        32'(m_tdata.charge_state));
                    check_field("time_to_empty_s", 32'(want.time_to_empty_s),
                        32'(m_tdata.time_to_empty_s));
                    check_field("time_to_full_s", 32'(want.time_to_full_s),
                        32'(m_tdata.time_to_full_s));
                    check_field("low_charge", 32'(want.low_charge),
                        32'(m_tdata.low_charge));
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("[battery_status_estimator] ERROR");
        $finish;
    end

    initial
    begin
        in_item_t base, r;
        int       ph;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        base = '0;
        base.battery_present = 1'b1;
        base.design_voltage_mv = 16'd12000;
        base.present_voltage_mv = 16'd11500;
        base.design_capacity = 16'd5000;
        base.last_full_capacity = 16'd4500;
        base.warning_capacity = 16'd300;
        base.present_rate = 16'd1500;
        base.remaining_capacity = 16'd3000;
        base.charge_flags = 3'b001;
        base.reported_percent = 7'd50;

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph / 2)
                0: begin send_gap_pct = 22; recv_stall_pct = 73; end
                1: begin send_gap_pct = 73; recv_stall_pct = 22; end
                default: begin send_gap_pct = 0; recv_stall_pct = 0; end
            endcase
            case (ph)
                1:
                begin
                    write_reg(CFG_LOW_PERCENT, 18'd0);
                    write_reg(CFG_ESTIMATE_LIMIT, 18'd0);
                end
                2:
                begin
                    write_reg(CFG_LOW_PERCENT, 18'd100);
                    write_reg(CFG_ESTIMATE_LIMIT, 18'd262143);
                end
                4:
                begin
                    write_reg(CFG_LOW_PERCENT, 18'd50);
                    write_reg(CFG_ESTIMATE_LIMIT, 18'd3600);
                end
                3, 5:
                begin
                    write_reg(CFG_LOW_PERCENT, 18'($urandom_range(100)));
                    write_reg(CFG_ESTIMATE_LIMIT, 18'($urandom_range(262143)));
                end
                default: ;
            endcase

            if (ph == 0)
            begin
                // absent battery with every other bit but the pad set
                r = '1;
                r.pad = '0;
                r.battery_present = 1'b0;
                push_reading(r);
                r = base;
                r.charge_flags = 3'b000;
                r.design_capacity = 16'hFFFF;
                r.last_full_capacity = 16'hFFFF;
                r.warning_capacity = 16'hFFFF;
                r.remaining_capacity = 16'hFFFF;
                r.present_rate = RATE_UNKNOWN;
                push_reading(r);
                // milliamp with design voltage fallback
                r = base;
                r.units_milliamp = 1'b1;
                r.design_voltage_mv = 16'd0;
                r.present_voltage_mv = 16'd0;
                r.reported_minutes = 17'h1FFFF;
                push_reading(r);
                r = base;
                r.units_milliamp = 1'b1;
                r.design_voltage_mv = 16'hFFFF;
                r.present_voltage_mv = 16'hFFFF;
                r.design_capacity = 16'hFFFF;
                r.last_full_capacity = 16'hFFFF;
                r.warning_capacity = 16'hFFFF;
                r.remaining_capacity = 16'hFFFF;
                r.present_rate = 16'hFFFE;
                r.charge_flags = 3'b010;
                push_reading(r);
                // present voltage above design gets clamped
                r = base;
                r.units_milliamp = 1'b1;
                r.design_voltage_mv = 16'd5000;
                r.present_voltage_mv = 16'd9000;
                push_reading(r);
                r = base;
                r.units_milliamp = 1'b1;
                r.design_voltage_mv = 16'd3700;
                r.present_voltage_mv = 16'd0;
                r.charge_flags = 3'b010;
                push_reading(r);
                r = base;
                r.reported_minutes = 17'd65535;
                push_reading(r);
                r = base;
                r.charge_flags = 3'b010;
                r.reported_minutes = 17'd90;
                push_reading(r);
                // full capacity below remaining while charging
                r = base;
                r.charge_flags = 3'b010;
                r.last_full_capacity = 16'd2000;
                r.present_rate = 16'd100;
                push_reading(r);
                // estimate past the limit
                r = base;
                r.charge_flags = 3'b010;
                r.last_full_capacity = 16'd60000;
                r.remaining_capacity = 16'd100;
                r.present_rate = 16'd1;
                push_reading(r);
                // no charge left
                r = base;
                r.remaining_capacity = 16'd0;
                r.present_rate = 16'd500;
                push_reading(r);
                r = base;
                r.present_rate = RATE_UNKNOWN;
                push_reading(r);
                for (int f = 3; f < 8; f++)
                begin
                    r = base;
                    r.charge_flags = 3'(f);
                    push_reading(r);
                end
                r = base;
                r.design_capacity = 16'd0;
                push_reading(r);
                r = base;
                r.last_full_capacity = 16'd0;
                push_reading(r);
                r = base;
                r.design_capacity = 16'd1;
                r.last_full_capacity = 16'hFFFF;
                push_reading(r);
                // low charge threshold edges
                r = base;
                r.reported_percent = 7'd0;
                push_reading(r);
                r.reported_percent = 7'd9;
                push_reading(r);
                r.reported_percent = 7'd10;
                push_reading(r);
                r.reported_percent = 7'd127;
                push_reading(r);
                r.charge_flags = 3'b010;
                r.reported_percent = 7'd0;
                push_reading(r);
            end

            repeat (280) push_reading(random_reading());
            while (n_checked != n_sent)
                @(negedge clk);
        end

        repeat (40) @(negedge clk);
        $display("Checked %0d of %0d readings over six threshold/limit settings",
            n_checked, n_sent);
        $display("with sender gaps, receiver stalls and back-to-back streaming; %0d mismatches",
            n_errors);
        if (n_errors == 0 && status_q.size() == 0)
            $display("[battery_status_estimator] OK");
        else
            $display("[battery_status_estimator] ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/bse_pkg.sv
hdl/bse_front.sv
hdl/bse_div.sv
hdl/bse_delay.sv
hdl/bse_out.sv
hdl/battery_status_estimator.sv
bench/battery_status_estimator_tb.sv
